// File: rtl/pte_pkg.sv
// Shared constants and types for the prefix tree engine.
`default_nettype none
package pte_pkg;

	// Tree geometry
	localparam int NODE_POOL  = 1024;
	localparam int ALPHABET   = 26;
	localparam int NODE_W     = $clog2(NODE_POOL);
	localparam int CNT_W      = $clog2(NODE_POOL + 1);
	localparam int SLOT_DEPTH = NODE_POOL * ALPHABET;
	localparam int SLOT_W     = $clog2(SLOT_DEPTH);
	localparam int LET_W      = 5;
	localparam int LIM_W      = 9;
	// Node row: child present bits, end mark on top
	localparam int ROW_W      = ALPHABET + 1;

	localparam logic [ROW_W-1:0] END_MASK = ROW_W'(1) << ALPHABET;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_PREFIX = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_ALLOC,
		ST_MARK
	} state_t;

endpackage
`default_nettype wire

// File: rtl/pte_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
`default_nettype none
module pte_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/prefix_tree_engine_core.sv
// Prefix tree engine top level: word walk sequencer over the node row and child link memories.
//
// One letter per command transfer; busy is high while an item is in work and start is taken only
// when busy is low. A letter down an existing edge is accepted, then ST_STEP uses the registered
// read of the cursor's node row and child link. A new node adds ST_ALLOC for the fresh row
// write, as the node row memory has a single write port. The last item of an insert or search
// that ends on a live node adds ST_MARK for the end-mark read-modify-write of that row (a read
// for a search). Clears, letters after a miss and other letterless items stay in ST_IDLE. The
// result (done, found, pool_full) appears the cycle after the item finishes and is valid for
// exactly one cycle; the receiver cannot stall it. No clearing pass runs after reset: rows are
// cleared as nodes are allocated and the root row is masked until first written.
`default_nettype none
module prefix_tree_engine_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic                       has_char,
	input  logic [pte_pkg::LET_W-1:0]  letter,
	input  logic                       first,
	input  logic                       last,
	output logic                       done,
	output logic                       found,
	output logic                       pool_full
);
	import pte_pkg::*;

	// Control state
	state_t             state_q, state_d;
	logic [NODE_W-1:0]  cursor_q, cursor_d;
	logic               missed_q, missed_d;
	logic               ovf_q, ovf_d;
	logic [CNT_W-1:0]   nodes_used_q, nodes_d;
	logic               root_valid_q, root_valid_d;
	logic               done_q, done_d;

	// Item payload held over the walk
	cmd_t               cmd_q, cmd_d;
	logic [LET_W-1:0]   letter_q, letter_d;
	logic               last_q, last_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic               found_q, found_d;
	logic               full_q, full_d;

	// Memory ports
	logic               row_we, row_re;
	logic [NODE_W-1:0]  row_waddr, row_raddr;
	logic [ROW_W-1:0]   row_wdata, row_rdata;
	logic               link_we, link_re;
	logic [SLOT_W-1:0]  link_waddr, link_raddr;
	logic [NODE_W-1:0]  link_wdata, link_rdata;

	// Walk helpers
	logic [NODE_W-1:0]  cur_eff;
	logic               miss_eff, ovf_eff, let_bad;
	logic [SLOT_W-1:0]  slot_in;
	logic [ROW_W-1:0]   row_eff;
	logic [ALPHABET-1:0] let_oh;
	logic               present;

	// End-of-word request
	logic               fin_req, fin_miss, fin_ovf;
	cmd_t               fin_cmd;
	logic [NODE_W-1:0]  fin_cur;

	pte_ram #(.DEPTH(NODE_POOL), .WIDTH(ROW_W)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	pte_ram #(.DEPTH(SLOT_DEPTH), .WIDTH(NODE_W)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// Cursor as seen by an incoming item: first restarts at the root
	assign cur_eff  = first ? '0 : cursor_q;
	assign miss_eff = first ? 1'b0 : missed_q;
	assign ovf_eff  = first ? 1'b0 : ovf_q;
	assign let_bad  = LIM_W'(letter) >= LIM_W'(ALPHABET);
	assign slot_in  = SLOT_W'(SLOT_W'(cur_eff) * SLOT_W'(ALPHABET)) + SLOT_W'(letter);

	// Root row reads as empty until written after reset or clear
	assign row_eff  = (cursor_q == '0 && !root_valid_q) ? '0 : row_rdata;
	assign let_oh   = ALPHABET'(1) << letter_q;
	assign present  = |(row_eff[ALPHABET-1:0] & let_oh);

	// Next state, memory controls and result
	always_comb begin
		state_d      = state_q;
		cursor_d     = cursor_q;
		missed_d     = missed_q;
		ovf_d        = ovf_q;
		nodes_d      = nodes_used_q;
		root_valid_d = root_valid_q;
		done_d       = 1'b0;
		cmd_d        = cmd_q;
		letter_d     = letter_q;
		last_d       = last_q;
		slot_d       = slot_q;
		found_d      = found_q;
		full_d       = full_q;
		row_we       = 1'b0;
		row_waddr    = cursor_q;
		row_wdata    = '0;
		row_re       = 1'b0;
		row_raddr    = cursor_q;
		link_we      = 1'b0;
		link_waddr   = slot_q;
		link_wdata   = nodes_used_q[NODE_W-1:0];
		link_re      = 1'b0;
		link_raddr   = slot_in;
		fin_req      = 1'b0;
		fin_cmd      = cmd_q;
		fin_cur      = cursor_q;
		fin_miss     = missed_q;
		fin_ovf      = ovf_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd_t'(cmd) == CMD_CLEAR) begin
						nodes_d      = CNT_W'(1);
						root_valid_d = 1'b0;
						cursor_d     = '0;
						missed_d     = 1'b0;
						ovf_d        = 1'b0;
						done_d       = 1'b1;
						found_d      = 1'b0;
						full_d       = 1'b0;
					end else begin
						cmd_d    = cmd_t'(cmd);
						letter_d = letter;
						last_d   = last;
						slot_d   = slot_in;
						cursor_d = cur_eff;
						missed_d = miss_eff;
						ovf_d    = ovf_eff;
						if (has_char && !miss_eff && !let_bad) begin
							// Fetch the cursor row and the child link together
							row_re    = 1'b1;
							row_raddr = cur_eff;
							link_re   = 1'b1;
							link_raddr = slot_in;
							state_d   = ST_STEP;
						end else begin
							missed_d = miss_eff | (has_char & let_bad);
							fin_req  = last;
							fin_cmd  = cmd_t'(cmd);
							fin_cur  = cur_eff;
							fin_miss = miss_eff | (has_char & let_bad);
							fin_ovf  = ovf_eff;
						end
					end
				end
			end
			ST_STEP: begin
				state_d = ST_IDLE;
				if (present) begin
					cursor_d = link_rdata;
					fin_req  = last_q;
					fin_cur  = link_rdata;
					fin_miss = 1'b0;
				end else if (cmd_q != CMD_INSERT) begin
					missed_d = 1'b1;
					fin_req  = last_q;
					fin_miss = 1'b1;
				end else if (nodes_used_q >= CNT_W'(NODE_POOL)) begin
					missed_d = 1'b1;
					ovf_d    = 1'b1;
					fin_req  = last_q;
					fin_miss = 1'b1;
					fin_ovf  = 1'b1;
				end else begin
					// Link the fresh node into the parent row
					row_we    = 1'b1;
					row_waddr = cursor_q;
					row_wdata = row_eff | ROW_W'(let_oh);
					if (cursor_q == '0) begin
						root_valid_d = 1'b1;
					end
					link_we   = 1'b1;
					cursor_d  = nodes_used_q[NODE_W-1:0];
					nodes_d   = nodes_used_q + CNT_W'(1);
					state_d   = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				// Fresh row starts empty; a word ending here is marked at once
				row_we    = 1'b1;
				row_waddr = cursor_q;
				row_wdata = (last_q && cmd_q == CMD_INSERT) ? END_MASK : '0;
				state_d   = ST_IDLE;
				if (last_q) begin
					done_d   = 1'b1;
					found_d  = 1'b1;
					full_d   = 1'b0;
					cursor_d = '0;
					missed_d = 1'b0;
					ovf_d    = 1'b0;
				end
			end
			ST_MARK: begin
				if (cmd_q == CMD_INSERT) begin
					row_we    = 1'b1;
					row_waddr = cursor_q;
					row_wdata = row_eff | END_MASK;
					if (cursor_q == '0) begin
						root_valid_d = 1'b1;
					end
					found_d = 1'b1;
				end else begin
					found_d = row_eff[ALPHABET];
				end
				full_d   = 1'b0;
				done_d   = 1'b1;
				cursor_d = '0;
				missed_d = 1'b0;
				ovf_d    = 1'b0;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// End of word: answer now, or read the end mark first
		if (fin_req) begin
			cursor_d = '0;
			missed_d = 1'b0;
			ovf_d    = 1'b0;
			state_d  = ST_IDLE;
			case (fin_cmd)
				CMD_INSERT: begin
					if (fin_ovf) begin
						done_d  = 1'b1;
						found_d = 1'b0;
						full_d  = 1'b1;
					end else if (!fin_miss) begin
						row_re    = 1'b1;
						row_raddr = fin_cur;
						cursor_d  = fin_cur;
						cmd_d     = fin_cmd;
						state_d   = ST_MARK;
					end else begin
						done_d  = 1'b1;
						found_d = 1'b0;
						full_d  = 1'b0;
					end
				end
				CMD_SEARCH: begin
					if (!fin_miss) begin
						row_re    = 1'b1;
						row_raddr = fin_cur;
						cursor_d  = fin_cur;
						cmd_d     = fin_cmd;
						state_d   = ST_MARK;
					end else begin
						done_d  = 1'b1;
						found_d = 1'b0;
						full_d  = 1'b0;
					end
				end
				default: begin
					done_d  = 1'b1;
					found_d = !fin_miss;
					full_d  = 1'b0;
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_q     <= '0;
			missed_q     <= 1'b0;
			ovf_q        <= 1'b0;
			nodes_used_q <= CNT_W'(1);
			root_valid_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			cursor_q     <= cursor_d;
			missed_q     <= missed_d;
			ovf_q        <= ovf_d;
			nodes_used_q <= nodes_d;
			root_valid_q <= root_valid_d;
			done_q       <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		letter_q <= letter_d;
		last_q   <= last_d;
		slot_q   <= slot_d;
		found_q  <= found_d;
		full_q   <= full_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign found     = found_q;
	assign pool_full = full_q;

	// A clear transfer answers in the next cycle with an empty result
	a_clear_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_CLEAR |=> done && !found && !pool_full)
		else $error("clear did not answer with an empty result");

	// An overflowed insert never reports the word as stored
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && pool_full |-> !found)
		else $error("pool_full reported together with found");

	// Allocation follows a step and takes exactly one node
	a_alloc_one_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |-> $past(state_q) == ST_STEP
			&& nodes_used_q == $past(nodes_used_q) + CNT_W'(1))
		else $error("allocation without a single node taken");

	// Node count stays within the pool
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> nodes_used_q <= CNT_W'(NODE_POOL) && nodes_used_q != '0)
		else $error("node count out of range");

endmodule
`default_nettype wire
